// ===== rtl/luma_glyph_rle_renderer_macros.svh =====
// Assertion macros for the luma glyph renderer.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef LUMA_GLYPH_RLE_RENDERER_MACROS_SVH
`define LUMA_GLYPH_RLE_RENDERER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define LGR_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("lgr assertion failed");

// next-cycle implication
`define LGR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("lgr assertion failed");

`else

`define LGR_ASSERT_IMPL(label, clk_s, rst_s, ante, cons)
`define LGR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== rtl/lgr_pkg.sv =====
// Shared types, constants and codes for the luma glyph renderer.
// No dependencies; imported by every module of the block.
package lgr_pkg;

    localparam int GLYPH_LEVELS = 64;
    localparam int CHUNK_PIXELS = 32;
    localparam int LEVEL_W      = $clog2(GLYPH_LEVELS);
    localparam int CHUNK_W      = $clog2(CHUNK_PIXELS);
    localparam int RUN_W        = CHUNK_W + 1;
    localparam int DIM_W        = 13;
    localparam int POS_W        = 12;
    localparam int THR_W        = 5;

    localparam logic [DIM_W-1:0] DIM_MAX        = 13'd4096;
    localparam logic [DIM_W-1:0] ROW_WIDTH_RST  = 13'd80;
    localparam logic [DIM_W-1:0] ROW_COUNT_RST  = 13'd24;
    localparam logic [THR_W-1:0] MIN_REPEAT_RST = 5'd4;
    localparam logic [THR_W-1:0] MIN_REPEAT_LO  = 5'd2;

    localparam logic [15:0] LUMA_KR   = 16'd77;
    localparam logic [15:0] LUMA_KG   = 16'd150;
    localparam logic [15:0] LUMA_KB   = 16'd29;
    localparam logic [15:0] LUMA_RND  = 16'd128;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_REP    = 8'h62;
    localparam logic [7:0] CH_SGR    = 8'h6D;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [1:0] CFG_ROW_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] CFG_MIN_REPEAT = 2'd2;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [RUN_W-1:0]   run_len_t;

    typedef struct packed {
        logic        req_type;
        logic [5:0]  glyph_slot;
        logic [31:0] glyph_bytes;
        logic [2:0]  glyph_length;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } in_item_t;

    typedef struct packed {
        logic [39:0] token_bytes;
        logic [2:0]  token_length;
        logic        last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] bytes;
    } glyph_entry_t;

    typedef struct packed {
        logic         en;
        level_t       addr;
        glyph_entry_t data;
    } mem_wr_t;

    typedef struct packed {
        logic   en;
        level_t addr_a;
        level_t addr_b;
    } mem_rd_t;

    // tokens owed for one pixel: earlier run, current run, row end
    typedef struct packed {
        logic     a_en;
        run_len_t a_len;
        logic     b_en;
        run_len_t b_len;
        logic     row_end;
        logic     last;
    } job_t;

    typedef enum logic [1:0] {
        PH_GLYPH,
        PH_REPEAT,
        PH_RESET,
        PH_NEWLINE
    } phase_t;

endpackage

// ===== rtl/luma_glyph_rle_renderer.sv =====
// Luma glyph renderer top level: configuration registers and the three stages.
// Depends on lgr_pkg, lgr_glyph_mem, lgr_run_tracker, lgr_token_emitter.
//
// Usage:
//   in channel  (in_valid/in_ready, in_item): glyph loads and RGB pixels in
//     raster order. Load every glyph slot a frame uses before its pixels.
//   out channel (out_valid/out_ready, out_item): text tokens of 1 to 5 bytes,
//     glyphs, repeat escapes, ESC [0m at row end and a newline between rows.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): row_width,
//     row_count, min_repeat_run; always ready, write only while idle.
// Path: an accepted pixel passes the input register, then the job register,
//   then the output register that holds its first token.
// Throughput: an item that owes no token is taken every cycle; otherwise the
//   token sequencer sends one token per cycle while out_ready is high, and a
//   pixel closing runs holds the input until the sequencer takes its job.
// Reset: counters clear, no run is open, registers take 80 / 24 / 4; glyph
//   table contents are undefined until loaded.
// Stall: the output register holds its token while out_ready is low; the job
//   and input registers then fill and in_ready drops.
`include "luma_glyph_rle_renderer_macros.svh"

module luma_glyph_rle_renderer
    import lgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    logic [DIM_W-1:0] row_width_reg;
    logic [DIM_W-1:0] row_count_reg;
    logic [THR_W-1:0] min_repeat_reg;

    logic         job_ready;
    logic         job_load;
    job_t         job;
    mem_wr_t      mem_wr;
    mem_rd_t      mem_rd;
    glyph_entry_t rd_a;
    glyph_entry_t rd_b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg  <= ROW_WIDTH_RST;
            row_count_reg  <= ROW_COUNT_RST;
            min_repeat_reg <= MIN_REPEAT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROW_WIDTH:  row_width_reg  <= cfg_data;
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                CFG_MIN_REPEAT: min_repeat_reg <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    lgr_run_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .row_width (row_width_reg),
        .row_count (row_count_reg),
        .job_ready (job_ready),
        .job_load  (job_load),
        .job       (job),
        .mem_wr    (mem_wr),
        .mem_rd    (mem_rd)
    );

    lgr_glyph_mem u_mem (
        .clk  (clk),
        .wr   (mem_wr),
        .rd   (mem_rd),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    lgr_token_emitter u_emitter (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_load       (job_load),
        .job_in         (job),
        .rd_a           (rd_a),
        .rd_b           (rd_b),
        .min_repeat_run (min_repeat_reg),
        .job_ready      (job_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item)
    );

    // a job is never dropped on a busy sequencer
    `LGR_ASSERT_IMPL(a_job_slot_free, clk, rst_n, job_load, job_ready)
    // every job owes at least one token
    `LGR_ASSERT_IMPL(a_job_has_tokens, clk, rst_n, job_load, job.a_en || job.b_en || job.row_end)
    // frame end only marks the row reset token
    `LGR_ASSERT_IMPL(a_last_is_reset, clk, rst_n, out_valid && out_item.last_of_frame,
                     out_item.token_length == 3'd4)

endmodule

// ===== rtl/lgr_glyph_mem.sv =====
// Glyph table: one write port, two registered read ports.
// Depends on lgr_pkg.
module lgr_glyph_mem
    import lgr_pkg::*;
(
    input  logic         clk,
    input  mem_wr_t      wr,
    input  mem_rd_t      rd,
    output glyph_entry_t rd_a,
    output glyph_entry_t rd_b
);

    glyph_entry_t mem [GLYPH_LEVELS];
    glyph_entry_t rd_a_reg;
    glyph_entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_a_reg <= mem[rd.addr_a];
            rd_b_reg <= mem[rd.addr_b];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

// ===== rtl/lgr_run_tracker.sv =====
// Input register, luma and level, run and raster counters.
// Produces one job per pixel that owes tokens. Depends on lgr_pkg.
module lgr_run_tracker
    import lgr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    input  logic [DIM_W-1:0] row_width,
    input  logic [DIM_W-1:0] row_count,
    input  logic             job_ready,
    output logic             job_load,
    output job_t             job,
    output mem_wr_t          mem_wr,
    output mem_rd_t          mem_rd
);

    logic             s1_valid_reg;
    in_item_t         s1_item_reg;
    level_t           run_level_reg, run_level_next;
    run_len_t         run_len_reg, run_len_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;

    logic [15:0]      luma_sum;
    level_t           level;
    logic [DIM_W-1:0] width_eff, count_eff;
    logic [DIM_W-1:0] col_inc, row_inc;
    logic             close_a, close_b, row_end, row_last, has_tok, adv, is_pixel;
    run_len_t         cur_len;
    level_t           cur_level;
    logic [2:0]       len_c;
    logic [31:0]      bytes_c;

    assign is_pixel = (s1_item_reg.req_type == REQ_PIXEL);

    always_comb
    begin
        luma_sum = 16'(LUMA_KR * 16'(s1_item_reg.red) + LUMA_KG * 16'(s1_item_reg.green)
                     + LUMA_KB * 16'(s1_item_reg.blue) + LUMA_RND);
        level = luma_sum[15 -: LEVEL_W];

        width_eff = (row_width == '0) ? 13'd1 : ((row_width > DIM_MAX) ? DIM_MAX : row_width);
        count_eff = (row_count == '0) ? 13'd1 : ((row_count > DIM_MAX) ? DIM_MAX : row_count);

        close_a   = (run_len_reg != '0) && (level != run_level_reg);
        cur_len   = (run_len_reg == '0 || close_a) ? run_len_t'(1) : run_len_reg + run_len_t'(1);
        cur_level = (run_len_reg == '0 || close_a) ? level : run_level_reg;

        col_inc  = {1'b0, col_reg} + 13'd1;
        row_inc  = {1'b0, row_reg} + 13'd1;
        row_end  = (col_inc >= width_eff);
        row_last = (row_inc >= count_eff);
        // chunk boundary: column count reaches a multiple of the chunk size
        close_b  = row_end || (col_inc[CHUNK_W-1:0] == '0);
        has_tok  = close_a || close_b;

        run_level_next = cur_level;
        run_len_next   = close_b ? '0 : cur_len;
        col_next       = row_end ? '0 : col_inc[POS_W-1:0];
        row_next       = row_end ? (row_last ? '0 : row_inc[POS_W-1:0]) : row_reg;
    end

    assign adv      = s1_valid_reg && (!is_pixel || !has_tok || job_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign job_load = adv && is_pixel && has_tok;

    always_comb
    begin
        job.a_en    = close_a;
        job.a_len   = run_len_reg;
        job.b_en    = close_b;
        job.b_len   = cur_len;
        job.row_end = row_end;
        job.last    = row_last;
    end

    always_comb
    begin
        case (s1_item_reg.glyph_length)
            3'd0, 3'd1: len_c = 3'd1;
            3'd2:       len_c = 3'd2;
            3'd3:       len_c = 3'd3;
            default:    len_c = 3'd4;
        endcase
        case (len_c)
            3'd1:    bytes_c = {24'h0, s1_item_reg.glyph_bytes[7:0]};
            3'd2:    bytes_c = {16'h0, s1_item_reg.glyph_bytes[15:0]};
            3'd3:    bytes_c = {8'h0, s1_item_reg.glyph_bytes[23:0]};
            default: bytes_c = s1_item_reg.glyph_bytes;
        endcase
        mem_wr.en         = adv && !is_pixel;
        mem_wr.addr       = s1_item_reg.glyph_slot;
        mem_wr.data.len   = len_c;
        mem_wr.data.bytes = bytes_c;
    end

    // table read lines up with the job register in the emitter
    assign mem_rd.en     = job_load;
    assign mem_rd.addr_a = run_level_reg;
    assign mem_rd.addr_b = cur_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            run_level_reg <= '0;
            run_len_reg   <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv && is_pixel)
            begin
                run_level_reg <= run_level_next;
                run_len_reg   <= run_len_next;
                col_reg       <= col_next;
                row_reg       <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

endmodule

// ===== rtl/lgr_token_emitter.sv =====
// Job register, token sequencer and output register.
// One token per cycle while the receiver takes them. Depends on lgr_pkg.
module lgr_token_emitter
    import lgr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_load,
    input  job_t             job_in,
    input  glyph_entry_t     rd_a,
    input  glyph_entry_t     rd_b,
    input  logic [THR_W-1:0] min_repeat_run,
    output logic             job_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item
);

    logic      job_valid_reg;
    job_t      job_reg;
    phase_t    phase_reg, phase_next;
    logic      sel_reg, sel_next;
    run_len_t  cnt_reg, cnt_next;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    out_item_t        tok;
    logic             fin, run_done, step;
    run_len_t         run_len;
    glyph_entry_t     glyph;
    logic [THR_W-1:0] thr;
    logic [4:0]       rc, units_w;
    logic [1:0]       tens;
    logic [3:0]       units;

    assign step      = job_valid_reg && (!out_valid_reg || out_ready);
    assign job_ready = !job_valid_reg || (step && fin);
    assign thr       = (min_repeat_run < MIN_REPEAT_LO) ? MIN_REPEAT_LO : min_repeat_run;

    always_comb
    begin
        run_len = sel_reg ? job_reg.b_len : job_reg.a_len;
        glyph   = sel_reg ? rd_b : rd_a;
        rc      = 5'(run_len - run_len_t'(1));
        if (rc >= 5'd30)
        begin
            tens = 2'd3;
        end
        else if (rc >= 5'd20)
        begin
            tens = 2'd2;
        end
        else if (rc >= 5'd10)
        begin
            tens = 2'd1;
        end
        else
        begin
            tens = 2'd0;
        end
        case (tens)
            2'd1:    units_w = rc - 5'd10;
            2'd2:    units_w = rc - 5'd20;
            2'd3:    units_w = rc - 5'd30;
            default: units_w = rc;
        endcase
        units = units_w[3:0];

        tok        = '0;
        phase_next = phase_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        fin        = 1'b0;
        run_done   = 1'b0;

        case (phase_reg)
            PH_GLYPH:
            begin
                tok.token_bytes  = {8'h00, glyph.bytes};
                tok.token_length = glyph.len;
                if (run_len >= RUN_W'(thr))
                begin
                    phase_next = PH_REPEAT;
                end
                else if (cnt_reg + run_len_t'(1) < run_len)
                begin
                    cnt_next = cnt_reg + run_len_t'(1);
                end
                else
                begin
                    run_done = 1'b1;
                end
            end
            PH_REPEAT:
            begin
                if (tens == 2'd0)
                begin
                    tok.token_bytes  = {8'h00, CH_REP, CH_ZERO + 8'(units), CH_LBRACK, CH_ESC};
                    tok.token_length = 3'd4;
                end
                else
                begin
                    tok.token_bytes  = {CH_REP, CH_ZERO + 8'(units), CH_ZERO + 8'(tens),
                                        CH_LBRACK, CH_ESC};
                    tok.token_length = 3'd5;
                end
                run_done = 1'b1;
            end
            PH_RESET:
            begin
                tok.token_bytes   = {8'h00, CH_SGR, CH_ZERO, CH_LBRACK, CH_ESC};
                tok.token_length  = 3'd4;
                tok.last_of_frame = job_reg.last;
                if (job_reg.last)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    phase_next = PH_NEWLINE;
                end
            end
            PH_NEWLINE:
            begin
                tok.token_bytes  = {32'h0, CH_NL};
                tok.token_length = 3'd1;
                fin = 1'b1;
            end
            default:
            begin
                fin = 1'b1;
            end
        endcase

        // after a run, move to the chunk-closed run if owed, then to the row end if owed
        if (run_done)
        begin
            if (!sel_reg && job_reg.b_en)
            begin
                sel_next   = 1'b1;
                phase_next = PH_GLYPH;
                cnt_next   = '0;
            end
            else if (job_reg.row_end)
            begin
                phase_next = PH_RESET;
            end
            else
            begin
                fin = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            phase_reg     <= PH_GLYPH;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
            begin
                job_valid_reg <= 1'b1;
                phase_reg     <= (job_in.a_en || job_in.b_en) ? PH_GLYPH : PH_RESET;
                sel_reg       <= !job_in.a_en;
                cnt_reg       <= '0;
            end
            else if (step)
            begin
                if (fin)
                begin
                    job_valid_reg <= 1'b0;
                end
                phase_reg <= phase_next;
                sel_reg   <= sel_next;
                cnt_reg   <= cnt_next;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job_in;
        end
        if (step)
        begin
            out_item_reg <= tok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
